FILE: hw/rtl/wrrps_pkg.sv
// ----------------------------------------------------------------------------
// wrrps_pkg: shared types and constants of the WRR poll scheduler
// Holds the sequencer state type, the GCD unit request and response
// bundles, and the fixed field widths.
// ----------------------------------------------------------------------------
package wrrps_pkg;

  localparam int unsigned WEIGHT_W  = 16;  // width of one weight register
  localparam int unsigned QIDX_W    = 3;   // width of the granted slot field
  localparam int unsigned CFG_IDX_W = 4;   // register index width, room for strays
  localparam int unsigned NUM_REGS  = 8;   // weight registers in the map
  localparam int unsigned SHIFT_W   = 4;   // common power-of-two count in GCD

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DERIVE,
    ST_GCD_WAIT,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                start;
    logic [WEIGHT_W-1:0] a;
    logic [WEIGHT_W-1:0] b;
  } gcd_req_t;

  typedef struct packed {
    logic                done;
    logic [WEIGHT_W-1:0] result;
  } gcd_rsp_t;

endpackage

FILE: hw/rtl/wrrps_weight_regs.sv
// ----------------------------------------------------------------------------
// wrrps_weight_regs: weight register file
// Decodes configuration writes, stores one weight per implemented slot and
// flags every write that lands in the register map.
// ----------------------------------------------------------------------------
module wrrps_weight_regs #(
  parameter int unsigned NUM_QUEUES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wrrps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wrrps_pkg::WEIGHT_W-1:0]      cfg_data_i,
  output logic [wrrps_pkg::WEIGHT_W-1:0]      weight_o [NUM_QUEUES],
  output logic                                cfg_hit_o
);

  logic [wrrps_pkg::WEIGHT_W-1:0] weight_q [NUM_QUEUES];

  // any index inside the map marks derived values stale, implemented or not
  assign cfg_hit_o = cfg_we_i &&
                     (cfg_index_i < wrrps_pkg::CFG_IDX_W'(wrrps_pkg::NUM_REGS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_QUEUES; s++) begin
        weight_q[s] <= '0;
      end
    end else begin
      for (int s = 0; s < NUM_QUEUES; s++) begin
        if (cfg_we_i && (cfg_index_i == wrrps_pkg::CFG_IDX_W'(s))) begin
          weight_q[s] <= cfg_data_i;
        end
      end
    end
  end

  assign weight_o = weight_q;

endmodule

FILE: hw/rtl/wrrps_gcd_unit.sv
// ----------------------------------------------------------------------------
// wrrps_gcd_unit: iterative binary GCD
// Takes two nonzero weights and reduces them one shift or one subtract per
// cycle; done is high for one cycle with the divisor.
// ----------------------------------------------------------------------------
module wrrps_gcd_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wrrps_pkg::gcd_req_t req_i,
  output wrrps_pkg::gcd_rsp_t rsp_o
);

  logic                            run_q, run_d;
  logic [wrrps_pkg::WEIGHT_W-1:0]  a_q, a_d;
  logic [wrrps_pkg::WEIGHT_W-1:0]  b_q, b_d;
  logic [wrrps_pkg::SHIFT_W-1:0]   k_q, k_d;
  logic                            finish;

  assign finish = run_q && ((a_q == '0) || (b_q == '0));

  always_comb begin
    run_d = run_q;
    a_d   = a_q;
    b_d   = b_q;
    k_d   = k_q;
    if (req_i.start) begin
      run_d = 1'b1;
      a_d   = req_i.a;
      b_d   = req_i.b;
      k_d   = '0;
    end else if (finish) begin
      run_d = 1'b0;
    end else if (run_q) begin
      if (!a_q[0] && !b_q[0]) begin
        // pull out a common factor of two
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q >= b_q) begin
        a_d = a_q - b_q;
      end else begin
        b_d = b_q - a_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      k_q   <= '0;
    end else begin
      run_q <= run_d;
      k_q   <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign rsp_o.done   = finish;
  assign rsp_o.result = wrrps_pkg::WEIGHT_W'((a_q | b_q) << k_q);

`ifndef SYNTH
  a_start_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> ((req_i.a != '0) && (req_i.b != '0)))
    else $error("gcd started with a zero operand");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !run_q)
    else $error("gcd restarted while running");

  a_run_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> ((a_q != '0) || (b_q != '0)))
    else $error("gcd operands both collapsed to zero");
`endif

endmodule

FILE: hw/rtl/weighted_round_robin_poll_scheduler.sv
// ----------------------------------------------------------------------------
// weighted_round_robin_poll_scheduler: weighted round robin poll grant
// Each poll item returns the next queue slot whose weight reaches the
// running current weight, stepping the current weight down by the weight
// GCD on every wrap to slot 0 and reloading it to the largest weight.
// ----------------------------------------------------------------------------
// Usage:
//   Write weights through cfg_we_i / cfg_index_i / cfg_data_i while idle;
//   index 0..7 is weight_q0..weight_q7, zero disables a slot, indexes past
//   seven are dropped. Any write in the map restarts the sequence and marks
//   the largest weight and the GCD stale.
//   Send a poll item on in_valid_i / in_ready_o with restart_i; one result
//   item comes back on out_valid_o / out_ready_i with queue_index_o,
//   none_enabled_o and round_start_o.
//   A poll goes through the check state, then the scan, which looks at one
//   slot after another (1 to 2*NUM_QUEUES+1 slots), then the emit state that
//   loads the output register; with no slot enrolled the scan is skipped. A
//   poll after reset or a weight write first walks every slot for the largest
//   weight and runs the binary GCD once per further enrolled slot.
//   in_ready_o is high only while the sequencer is idle; one item at a time.
//   Reset clears all weights, the current weight and the derived values;
//   the first poll then reports none_enabled.
//   A stalled receiver holds the result in the output register; the next
//   item is still taken and waits for that register before it is emitted.
// ----------------------------------------------------------------------------
module weighted_round_robin_poll_scheduler #(
  parameter int unsigned NUM_QUEUES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [wrrps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wrrps_pkg::WEIGHT_W-1:0]      cfg_data_i,
  // poll item
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                restart_i,
  // grant item
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [wrrps_pkg::QIDX_W-1:0]        queue_index_o,
  output logic                                none_enabled_o,
  output logic                                round_start_o
);

  localparam int unsigned IDX_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned ITER_W    = $clog2(2 * NUM_QUEUES + 1);
  localparam int unsigned LAST_SLOT = NUM_QUEUES - 1;
  localparam int unsigned ITER_LAST = 2 * NUM_QUEUES;

  // weight register file
  logic [wrrps_pkg::WEIGHT_W-1:0] weight [NUM_QUEUES];
  logic                           cfg_hit;

  wrrps_weight_regs #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .weight_o    (weight),
    .cfg_hit_o   (cfg_hit)
  );

  // shared GCD unit
  wrrps_pkg::gcd_req_t gcd_req;
  wrrps_pkg::gcd_rsp_t gcd_rsp;

  wrrps_gcd_unit u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (gcd_req),
    .rsp_o  (gcd_rsp)
  );

  // sequencer and architectural state
  wrrps_pkg::state_e              state_q, state_d;
  logic [wrrps_pkg::WEIGHT_W-1:0] cw_q, cw_d;          // current weight
  logic [IDX_W-1:0]               last_q, last_d;      // last granted slot
  logic [wrrps_pkg::WEIGHT_W-1:0] max_q, max_d;
  logic [wrrps_pkg::WEIGHT_W-1:0] gcd_q, gcd_d;
  logic                           derived_q, derived_d;
  logic [IDX_W-1:0]               ptr_q, ptr_d;        // slot under the walk or scan
  logic [ITER_W-1:0]              iter_q, iter_d;
  logic                           rel_q, rel_d;        // reloaded during this scan
  // pending result and output register
  logic [IDX_W-1:0]               res_idx_q, res_idx_d;
  logic                           res_none_q, res_none_d;
  logic                           res_round_q, res_round_d;
  logic                           out_valid_q, out_valid_d;
  logic [wrrps_pkg::QIDX_W-1:0]   out_idx_q, out_idx_d;
  logic                           out_none_q, out_none_d;
  logic                           out_round_q, out_round_d;

  logic                           in_fire;
  logic                           out_free;
  logic [wrrps_pkg::WEIGHT_W-1:0] w_sel;
  logic [IDX_W-1:0]               ptr_next;
  logic [IDX_W-1:0]               last_next;
  logic                           ptr_at_last;
  logic                           reload;
  logic [wrrps_pkg::WEIGHT_W-1:0] cw_eff;
  logic                           hit;
  logic                           scan_end;
  logic                           gcd_launch;

  assign in_ready_o = (state_q == wrrps_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // one weight read port, shared by the max walk and the scan
  assign w_sel       = weight[ptr_q];
  assign ptr_at_last = (ptr_q == IDX_W'(LAST_SLOT));
  assign ptr_next    = ptr_at_last ? '0 : ptr_q + 1'b1;
  assign last_next   = (last_q == IDX_W'(LAST_SLOT)) ? '0 : last_q + 1'b1;

  // step the current weight on a wrap to slot 0, reload at or below the divisor
  always_comb begin
    reload = 1'b0;
    cw_eff = cw_q;
    if (ptr_q == '0) begin
      if (cw_q <= gcd_q) begin
        reload = 1'b1;
        cw_eff = max_q;
      end else begin
        cw_eff = cw_q - gcd_q;
      end
    end
  end

  assign hit        = (w_sel != '0) && (w_sel >= cw_eff);
  assign scan_end   = hit || (iter_q == ITER_W'(ITER_LAST));
  assign gcd_launch = (w_sel != '0) && (gcd_q != '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wrrps_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = derived_q ? wrrps_pkg::ST_CHECK : wrrps_pkg::ST_DERIVE;
        end
      end
      wrrps_pkg::ST_DERIVE: begin
        if (gcd_launch) begin
          state_d = wrrps_pkg::ST_GCD_WAIT;
        end else if (ptr_at_last) begin
          state_d = wrrps_pkg::ST_CHECK;
        end
      end
      wrrps_pkg::ST_GCD_WAIT: begin
        if (gcd_rsp.done) begin
          state_d = ptr_at_last ? wrrps_pkg::ST_CHECK : wrrps_pkg::ST_DERIVE;
        end
      end
      wrrps_pkg::ST_CHECK: begin
        state_d = (max_q == '0) ? wrrps_pkg::ST_EMIT : wrrps_pkg::ST_SCAN;
      end
      wrrps_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = wrrps_pkg::ST_EMIT;
        end
      end
      wrrps_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = wrrps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wrrps_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    cw_d        = cw_q;
    last_d      = last_q;
    max_d       = max_q;
    gcd_d       = gcd_q;
    derived_d   = derived_q;
    ptr_d       = ptr_q;
    iter_d      = iter_q;
    rel_d       = rel_q;
    res_idx_d   = res_idx_q;
    res_none_d  = res_none_q;
    res_round_d = res_round_q;
    out_idx_d   = out_idx_q;
    out_none_d  = out_none_q;
    out_round_d = out_round_q;
    out_valid_d = out_valid_q && !out_ready_i;
    gcd_req.start = 1'b0;
    gcd_req.a     = gcd_q;
    gcd_req.b     = w_sel;

    case (state_q)
      wrrps_pkg::ST_IDLE: begin
        if (cfg_hit) begin
          // a weight write restarts the sequence and drops the derived values
          cw_d      = '0;
          last_d    = IDX_W'(LAST_SLOT);
          derived_d = 1'b0;
        end
        if (in_fire) begin
          if (restart_i) begin
            cw_d   = '0;
            last_d = IDX_W'(LAST_SLOT);
          end
          if (!derived_q) begin
            ptr_d = '0;
            max_d = '0;
            gcd_d = '0;
          end
        end
      end
      wrrps_pkg::ST_DERIVE: begin
        if (w_sel != '0) begin
          if (w_sel > max_q) begin
            max_d = w_sel;
          end
          if (gcd_q == '0) begin
            gcd_d = w_sel;
          end
        end
        if (gcd_launch) begin
          gcd_req.start = 1'b1;
        end else if (ptr_at_last) begin
          derived_d = 1'b1;
        end else begin
          ptr_d = ptr_next;
        end
      end
      wrrps_pkg::ST_GCD_WAIT: begin
        if (gcd_rsp.done) begin
          gcd_d = gcd_rsp.result;
          if (ptr_at_last) begin
            derived_d = 1'b1;
          end else begin
            ptr_d = ptr_next;
          end
        end
      end
      wrrps_pkg::ST_CHECK: begin
        if (max_q == '0) begin
          // nothing enrolled: report it and leave the sequence alone
          res_idx_d   = '0;
          res_none_d  = 1'b1;
          res_round_d = 1'b0;
        end else begin
          ptr_d  = last_next;
          iter_d = '0;
          rel_d  = 1'b0;
        end
      end
      wrrps_pkg::ST_SCAN: begin
        cw_d  = cw_eff;
        rel_d = rel_q || reload;
        if (scan_end) begin
          last_d      = ptr_q;
          res_idx_d   = ptr_q;
          res_none_d  = 1'b0;
          res_round_d = rel_q || reload;
        end else begin
          ptr_d  = ptr_next;
          iter_d = iter_q + 1'b1;
        end
      end
      wrrps_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = wrrps_pkg::QIDX_W'(res_idx_q);
          out_none_d  = res_none_q;
          out_round_d = res_round_q;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wrrps_pkg::ST_IDLE;
      cw_q        <= '0;
      last_q      <= IDX_W'(LAST_SLOT);
      max_q       <= '0;
      gcd_q       <= '0;
      derived_q   <= 1'b0;
      ptr_q       <= '0;
      iter_q      <= '0;
      rel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cw_q        <= cw_d;
      last_q      <= last_d;
      max_q       <= max_d;
      gcd_q       <= gcd_d;
      derived_q   <= derived_d;
      ptr_q       <= ptr_d;
      iter_q      <= iter_d;
      rel_q       <= rel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers hold their item, no reset needed
  always_ff @(posedge clk_i) begin
    res_idx_q   <= res_idx_d;
    res_none_q  <= res_none_d;
    res_round_q <= res_round_d;
    out_idx_q   <= out_idx_d;
    out_none_q  <= out_none_d;
    out_round_q <= out_round_d;
  end

  assign out_valid_o    = out_valid_q;
  assign queue_index_o  = out_idx_q;
  assign none_enabled_o = out_none_q;
  assign round_start_o  = out_round_q;

`ifndef SYNTH
  a_scan_needs_weights: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wrrps_pkg::ST_SCAN) |-> ((max_q != '0) && (gcd_q != '0)))
    else $error("scan entered without derived weights");

  a_none_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && none_enabled_o) |-> ((queue_index_o == '0) && !round_start_o))
    else $error("none_enabled item carries a grant");

  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !none_enabled_o) |->
      (queue_index_o <= wrrps_pkg::QIDX_W'(LAST_SLOT)))
    else $error("granted slot beyond the implemented queues");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("second item taken while the first is at work");
`endif

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the weighted round robin poll scheduler
// Programs the eight slot weights and sends poll items, some with the
// restart bit set. A model of the grant sequence runs alongside the block.
// It tracks the current weight, the last slot, the largest weight and the
// weight divisor, and it predicts every grant item. A monitor compares each
// grant field by field. Directed cases come first, then random weight maps
// with random gaps on the poll side and random stalls on the grant side.
// ----------------------------------------------------------------------------
module tb_top;
  import wrrps_pkg::*;

  localparam int NUM_Q = 8;

  // Register map: slot weights sit at consecutive indexes from REG_WEIGHT_Q0.
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Q0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Q7 = 4'd7;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_IDX  = 4'd15;

  localparam int RANDOM_POLLS = 675;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES  = 60;

  typedef struct packed {
    logic [QIDX_W-1:0] qidx;
    logic              none;
    logic              rstart;
  } grant_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [WEIGHT_W-1:0]  cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 restart_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [QIDX_W-1:0]    queue_index_o;
  logic                 none_enabled_o;
  logic                 round_start_o;

  weighted_round_robin_poll_scheduler #(
    .NUM_QUEUES(NUM_Q)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .queue_index_o (queue_index_o),
    .none_enabled_o(none_enabled_o),
    .round_start_o (round_start_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Grant sequence model
  // --------------------------------------------------------------------------
  logic [WEIGHT_W-1:0] slot_wt [NUM_Q];
  logic [WEIGHT_W-1:0] cur_wt = '0;
  logic [QIDX_W-1:0]   last_slot = QIDX_W'(NUM_Q - 1);
  logic [WEIGHT_W-1:0] top_wt = '0;
  logic [WEIGHT_W-1:0] wt_gcd = '0;
  bit                  derived_ok = 1'b0;

  grant_t grant_q[$];

  int errors = 0;
  int polls_sent = 0;
  int grants_seen = 0;
  int empty_seen = 0;
  int rounds_seen = 0;
  int weight_writes = 0;
  int slot_hits [NUM_Q];
  bit quiet = 1'b0;

  initial begin
    foreach (slot_wt[s]) slot_wt[s] = '0;
    foreach (slot_hits[s]) slot_hits[s] = 0;
  end

  function automatic logic [WEIGHT_W-1:0] euclid_gcd(logic [WEIGHT_W-1:0] a,
                                                     logic [WEIGHT_W-1:0] b);
    logic [WEIGHT_W-1:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Rewind to the start of the sequence: next slot stepped to is slot 0.
  function automatic void rewind_sequence();
    cur_wt = '0;
    last_slot = QIDX_W'(NUM_Q - 1);
  endfunction

  function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] data);
    if (idx <= REG_WEIGHT_Q7) begin
      slot_wt[idx - REG_WEIGHT_Q0] = data;
      derived_ok = 1'b0;
      rewind_sequence();
    end
  endfunction

  function automatic grant_t predict_grant(logic rst);
    grant_t g;
    int     q;
    bit     hit;
    g = '0;
    if (rst) rewind_sequence();
    // Rebuild the largest weight and the divisor over enrolled slots only.
    if (!derived_ok) begin
      top_wt = '0;
      wt_gcd = '0;
      for (int s = 0; s < NUM_Q; s++) begin
        if (slot_wt[s] != 0) begin
          if (slot_wt[s] > top_wt) top_wt = slot_wt[s];
          wt_gcd = (wt_gcd != 0) ? euclid_gcd(wt_gcd, slot_wt[s]) : slot_wt[s];
        end
      end
      derived_ok = 1'b1;
    end
    if (top_wt == 0) begin
      g.none = 1'b1;
      return g;
    end
    q = last_slot;
    hit = 1'b0;
    for (int step = 0; step < 2 * NUM_Q + 1 && !hit; step++) begin
      q = (q + 1) % NUM_Q;
      // Drop the current weight on each wrap; reload once it would hit zero.
      if (q == 0) begin
        if (cur_wt <= wt_gcd) begin
          cur_wt = top_wt;
          g.rstart = 1'b1;
        end else begin
          cur_wt = cur_wt - wt_gcd;
        end
      end
      if (slot_wt[q] != 0 && slot_wt[q] >= cur_wt) hit = 1'b1;
    end
    last_slot = QIDX_W'(q);
    g.qidx = QIDX_W'(q);
    return g;
  endfunction

  // --------------------------------------------------------------------------
  // Idle pattern: mostly back to back, some short gaps, a few long ones.
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Grant side: stall for random stretches, driven at the falling edge.
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // --------------------------------------------------------------------------
  // Grant monitor: compare each accepted grant with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (grant_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected grant: queue_index %0d none_enabled %0b round_start %0b",
                 $time, queue_index_o, none_enabled_o, round_start_o);
      end else begin
        want = grant_q.pop_front();
        if (queue_index_o !== want.qidx) begin
          errors++;
          $display("%0t: queue_index expected %0d actual %0d", $time, want.qidx, queue_index_o);
        end
        if (none_enabled_o !== want.none) begin
          errors++;
          $display("%0t: none_enabled expected %0b actual %0b",
                   $time, want.none, none_enabled_o);
        end
        if (round_start_o !== want.rstart) begin
          errors++;
          $display("%0t: round_start expected %0b actual %0b",
                   $time, want.rstart, round_start_o);
        end
        grants_seen++;
        if (want.none) empty_seen++;
        else slot_hits[want.qidx]++;
        if (want.rstart) rounds_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Send one poll item; hold valid and restart until the handshake, then
  // either leave valid up for the next item or drop it for a gap.
  task automatic send_poll(input logic rst);
    int gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    restart_i <= rst;
    do @(posedge clk_i); while (!in_ready_o);
    grant_q.push_back(predict_grant(rst));
    polls_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      restart_i <= 1'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Drop valid and hold off until every predicted grant has come back.
  task automatic drain_grants();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write one register for a single cycle; call only while drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    model_write(idx, data);
    weight_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_map(input logic [WEIGHT_W-1:0] w0, w1, w2, w3, w4, w5, w6, w7);
    logic [WEIGHT_W-1:0] w [NUM_Q];
    w = '{w0, w1, w2, w3, w4, w5, w6, w7};
    for (int s = 0; s < NUM_Q; s++) write_reg(REG_WEIGHT_Q0 + CFG_IDX_W'(s), w[s]);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Nothing enrolled after reset: grant none, with and without restart.
  task automatic test_empty_after_reset();
    send_poll(1'b0);
    send_poll(1'b1);
    drain_grants();
  endtask

  // Only the last slot enrolled, at full scale.
  task automatic test_single_last_slot();
    write_reg(REG_WEIGHT_Q7, 16'hFFFF);
    send_poll(1'b0);
    send_poll(1'b0);
    send_poll(1'b1);
    drain_grants();
  endtask

  // Equal weights walk every slot in turn.
  task automatic test_equal_weights();
    write_map(1, 1, 1, 1, 1, 1, 1, 1);
    repeat (NUM_Q) send_poll(1'b0);
    drain_grants();
  endtask

  // Weights with a divisor above one, slots past the third disabled.
  task automatic test_common_divisor();
    write_map(6, 9, 12, 0, 0, 0, 0, 0);
    repeat (3) send_poll(1'b0);
    send_poll(1'b1);
    repeat (2) send_poll(1'b0);
    drain_grants();
  endtask

  // Indexes past the map are dropped and leave the sequence running.
  task automatic test_stray_index();
    write_reg(REG_WEIGHT_Q7 + 1'b1, 16'h1234);
    write_reg(REG_LAST_IDX, 16'hFFFF);
    send_poll(1'b0);
    send_poll(1'b0);
    drain_grants();
  endtask

  // Full-scale and unit weights side by side: divisor of one, long rounds.
  task automatic test_full_scale_mix();
    write_map(16'hFFFF, 1, 0, 16'h8000, 0, 0, 0, 0);
    repeat (3) send_poll(1'b0);
    drain_grants();
  endtask

  // Clear the map again: back to no grant.
  task automatic test_clear_map();
    write_map(0, 0, 0, 0, 0, 0, 0, 0);
    send_poll(1'b0);
    drain_grants();
  endtask

  // --------------------------------------------------------------------------
  // Random test: phases of reprogramming followed by bursts of polls
  // --------------------------------------------------------------------------
  function automatic logic [WEIGHT_W-1:0] pick_weight(int profile, int unit);
    case (profile)
      0: begin
        return WEIGHT_W'($urandom_range(0, 8));
      end
      1: begin
        return WEIGHT_W'(unit * $urandom_range(0, 6));
      end
      2: begin
        return ($urandom_range(0, 4) == 0) ? '0 : WEIGHT_W'($urandom);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'h8000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  task automatic test_random_polls();
    int profile;
    int unit;
    int burst;
    int sent;
    sent = 0;
    while (sent < RANDOM_POLLS) begin
      drain_grants();
      // Reprogram: mostly the whole map, sometimes a few slots only.
      profile = $urandom_range(0, 3);
      unit = $urandom_range(2, 600);
      if ($urandom_range(0, 9) < 7) begin
        for (int s = 0; s < NUM_Q; s++) begin
          write_reg(REG_WEIGHT_Q0 + CFG_IDX_W'(s), pick_weight(profile, unit));
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          write_reg(REG_WEIGHT_Q0 + CFG_IDX_W'($urandom_range(0, NUM_Q - 1)),
                    pick_weight(profile, unit));
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_WEIGHT_Q7 + 1, REG_LAST_IDX)),
                  WEIGHT_W'($urandom));
      end
      // Some phases run with no idling on either side.
      quiet = ($urandom_range(0, 4) == 0);
      burst = $urandom_range(20, 60);
      for (int i = 0; i < burst; i++) begin
        send_poll($urandom_range(0, 7) == 0);
        // Now and then hold off mid-burst until all grants are back.
        if (i == burst / 2 && $urandom_range(0, 3) == 0) drain_grants();
      end
      sent += burst;
      quiet = 1'b0;
    end
    drain_grants();
  endtask

  // --------------------------------------------------------------------------
  // Sequence of tests
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_empty_after_reset();
    test_single_last_slot();
    test_equal_weights();
    test_common_divisor();
    test_stray_index();
    test_full_scale_mix();
    test_clear_map();
    test_random_polls();

    // Watch for stray grants after the last expected one.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (grant_q.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted grants never arrived", $time, grant_q.size());
    end

    $display("Polled %0d items over %0d weight writes: %0d grants, %0d with no slot enrolled.",
             polls_sent, weight_writes, grants_seen, empty_seen);
    $display("Round reloads %0d; grants per slot %0d %0d %0d %0d %0d %0d %0d %0d.",
             rounds_seen, slot_hits[0], slot_hits[1], slot_hits[2], slot_hits[3],
             slot_hits[4], slot_hits[5], slot_hits[6], slot_hits[7]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #10000000;
    $display("FAILURE");
    $finish;
  end

endmodule
